// ===== design/hat_pkg.sv =====
package hat_pkg;

   localparam int DefSlots   = 32;
   localparam int MaxResults = 30;
   localparam int FirstFree  = 3;
   localparam int SlotW      = 6;
   localparam int HostW      = 16;
   localparam int CountW     = 8;
   localparam int KindW      = 3;
   localparam int HandleW    = 8;
   localparam int RelCntW    = $clog2(MaxResults + 1);

   localparam logic [KindW-1:0] KindOpen   = 3'd0;
   localparam logic [KindW-1:0] KindClose  = 3'd1;
   localparam logic [KindW-1:0] KindLookup = 3'd2;
   localparam logic [KindW-1:0] KindAdd    = 3'd3;
   localparam logic [KindW-1:0] KindDrop   = 3'd4;

   typedef struct packed {
      logic capture;       // take the request beat
      logic exec;          // run the request, load result unless final drop
      logic scan_init;     // start release sweep
      logic scan_step;     // advance sweep pointer
      logic scan_rd;       // read table at sweep pointer
      logic emit_release;  // load release result
      logic emit_empty;    // load plain success after empty sweep
      logic sweep_clear;   // free all slots from FirstFree up
   } hat_cmd_type;

   typedef struct packed {
      logic out_free;
      logic final_drop;
      logic used_here;
      logic any_from_here;
      logic release_last;
   } hat_sts_type;

endpackage

// ===== design/hat_if.sv =====
interface hat_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [7:0] handle;
   logic [15:0]       host_handle;

   modport source (output valid, kind, handle, host_handle, input ready);
   modport sink   (input valid, kind, handle, host_handle, output ready);
endinterface

interface hat_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [5:0]  slot_out;
   logic [15:0] value_out;
   logic        is_release;
   logic        last;

   modport source (output valid, status, slot_out, value_out, is_release, last,
                   input ready);
   modport sink   (input valid, status, slot_out, value_out, is_release, last,
                   output ready);
endinterface

// ===== design/hat_ctrl.sv =====
module hat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hat_pkg::hat_sts_type sts,
   output hat_pkg::hat_cmd_type cmd
);
   import hat_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StExec = 3'd1;
   localparam logic [2:0] StScan = 3'd2;
   localparam logic [2:0] StOut  = 3'd3;
   localparam logic [2:0] StEnd  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = StExec;
            end
         end
         StExec: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               if (sts.final_drop) begin
                  cmd.scan_init = 1'b1;
                  state_in      = StScan;
               end else begin
                  state_in = StIdle;
               end
            end
         end
         StScan: begin
            if (!sts.any_from_here) begin
               state_in = StEnd;
            end else if (sts.used_here) begin
               cmd.scan_rd = 1'b1;
               state_in    = StOut;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         StOut: begin
            if (sts.out_free) begin
               cmd.emit_release = 1'b1;
               if (sts.release_last) begin
                  cmd.sweep_clear = 1'b1;
                  state_in        = StIdle;
               end else begin
                  cmd.scan_step = 1'b1;
                  state_in      = StScan;
               end
            end
         end
         StEnd: begin
            if (sts.out_free) begin
               cmd.emit_empty  = 1'b1;
               cmd.sweep_clear = 1'b1;
               state_in        = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

// ===== design/hat_dp.sv =====
module hat_dp #(
   parameter int SLOTS = hat_pkg::DefSlots
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hat_pkg::hat_cmd_type         cmd,
   output hat_pkg::hat_sts_type         sts,
   input  logic [hat_pkg::KindW-1:0]    req_kind,
   input  logic signed [hat_pkg::HandleW-1:0] req_handle,
   input  logic [hat_pkg::HostW-1:0]    req_host_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic [hat_pkg::SlotW-1:0]    rsp_slot_out,
   output logic [hat_pkg::HostW-1:0]    rsp_value_out,
   output logic                         rsp_is_release,
   output logic                         rsp_last
);
   import hat_pkg::*;

   localparam int IdxW = $clog2(SLOTS);

   // request beat
   logic [KindW-1:0]          kind_ff;
   logic signed [HandleW-1:0] handle_ff;
   logic [HostW-1:0]          host_ff;

   logic [SLOTS-1:0]     used_ff, used_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic [FirstFree-1:0] init_wr_ff, init_wr_in;
   logic [IdxW-1:0]      scan_ff, scan_in;
   logic [RelCntW-1:0]   rel_ff, rel_in;

   logic [HostW-1:0] mem [SLOTS];
   logic [HostW-1:0] rd_data_ff;
   logic [IdxW-1:0]  rd_addr_ff;
   logic             rd_dflt_ff;
   logic [IdxW-1:0]  rd_addr;
   logic             rd_en;
   logic [HostW-1:0] rd_value;

   logic             out_valid_ff;
   logic             out_status_ff, out_rel_ff, out_last_ff;
   logic [SlotW-1:0] out_slot_ff;
   logic [HostW-1:0] out_value_ff;
   logic             load;
   logic             ld_status, ld_rel, ld_last;
   logic [SlotW-1:0] ld_slot;
   logic [HostW-1:0] ld_value;

   logic            h_ok;
   logic [IdxW-1:0] h_idx;
   logic            free_found;
   logic [IdxW-1:0] free_idx;
   logic            wr_en;
   logic [SLOTS-1:0] ge_scan, gt_scan;

   assign h_idx = handle_ff[IdxW-1:0];
   assign h_ok  = !handle_ff[HandleW-1] && (int'(handle_ff[HandleW-2:0]) < SLOTS)
                  && used_ff[h_idx];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!free_found && !used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ge_scan[i] = used_ff[i] && (i >= int'(scan_ff));
         gt_scan[i] = used_ff[i] && (i > int'(scan_ff));
      end
   end

   assign sts.out_free      = !out_valid_ff || rsp_ready;
   assign sts.final_drop    = (kind_ff == KindDrop) && (count_ff == CountW'(1));
   assign sts.used_here     = used_ff[scan_ff];
   assign sts.any_from_here = |ge_scan;
   assign sts.release_last  = !(|gt_scan) || (rel_ff == RelCntW'(MaxResults - 1));

   // table memory, registered read
   assign rd_en   = cmd.capture || cmd.scan_rd;
   assign rd_addr = cmd.capture ? req_handle[IdxW-1:0] : scan_ff;
   assign wr_en   = cmd.exec && (kind_ff == KindOpen) && free_found;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_idx] <= host_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
         // reserved entries read as their index until first written
         rd_dflt_ff <= (int'(rd_addr) < FirstFree) &&
                       !init_wr_ff[rd_addr[1:0]];
      end
   end

   assign rd_value = rd_dflt_ff ? HostW'(rd_addr_ff) : rd_data_ff;

   always_comb begin
      used_in    = used_ff;
      count_in   = count_ff;
      init_wr_in = init_wr_ff;
      scan_in    = scan_ff;
      rel_in     = rel_ff;
      load       = 1'b0;
      ld_status  = 1'b1;
      ld_slot    = '0;
      ld_value   = '0;
      ld_rel     = 1'b0;
      ld_last    = 1'b1;
      if (cmd.exec) begin
         load = 1'b1;
         case (kind_ff)
            KindOpen: begin
               if (free_found) begin
                  used_in[free_idx] = 1'b1;
                  if (int'(free_idx) < FirstFree) begin
                     init_wr_in[free_idx[1:0]] = 1'b1;
                  end
                  ld_status = 1'b0;
                  ld_slot   = SlotW'(free_idx);
                  ld_value  = host_ff;
               end
            end
            KindClose: begin
               if (h_ok) begin
                  used_in[h_idx] = 1'b0;
                  ld_status      = 1'b0;
                  ld_slot        = SlotW'(h_idx);
               end
            end
            KindLookup: begin
               if (h_ok) begin
                  ld_status = 1'b0;
                  ld_slot   = SlotW'(h_idx);
                  ld_value  = rd_value;
               end
            end
            KindAdd: begin
               if (count_ff != '1) begin
                  count_in  = count_ff + CountW'(1);
                  ld_status = 1'b0;
               end
            end
            KindDrop: begin
               if (count_ff != '0) begin
                  count_in  = count_ff - CountW'(1);
                  ld_status = 1'b0;
                  // last user gone: results come from the sweep
                  load = (count_ff != CountW'(1));
               end
            end
            default: begin
               ld_status = 1'b1;
            end
         endcase
      end
      if (cmd.scan_init) begin
         scan_in = IdxW'(FirstFree);
         rel_in  = '0;
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + IdxW'(1);
      end
      if (cmd.emit_release) begin
         load      = 1'b1;
         ld_status = 1'b0;
         ld_slot   = SlotW'(scan_ff);
         ld_value  = rd_value;
         ld_rel    = 1'b1;
         ld_last   = sts.release_last;
         rel_in    = rel_ff + RelCntW'(1);
      end
      if (cmd.emit_empty) begin
         load      = 1'b1;
         ld_status = 1'b0;
      end
      if (cmd.sweep_clear) begin
         used_in = used_ff & {{(SLOTS - FirstFree){1'b0}}, {FirstFree{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= {{(SLOTS - FirstFree){1'b0}}, {FirstFree{1'b1}}};
         count_ff     <= '0;
         init_wr_ff   <= '0;
         scan_ff      <= '0;
         rel_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         count_ff   <= count_in;
         init_wr_ff <= init_wr_in;
         scan_ff    <= scan_in;
         rel_ff     <= rel_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         handle_ff <= req_handle;
         host_ff   <= req_host_handle;
      end
      if (load) begin
         out_status_ff <= ld_status;
         out_slot_ff   <= ld_slot;
         out_value_ff  <= ld_value;
         out_rel_ff    <= ld_rel;
         out_last_ff   <= ld_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_slot_out   = out_slot_ff;
   assign rsp_value_out  = out_value_ff;
   assign rsp_is_release = out_rel_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== design/handle_allocation_table.sv =====
// A beat is captured in idle; exec runs it and loads its result into the output
// register once that is free. No new request is taken until it and any sweep end.
// The last drop-user sweeps slots 3 up: free slots are skipped, each open slot gets one
// table read and a release result (at most 30), then 3..SLOTS-1 are freed; plain
// success if none open. Reset (synchronous): slots 0-2 open holding 0, 1, 2, user count
// zero; other table entries are undefined until opened, and no clearing pass runs.
module handle_allocation_table #(
   parameter int SLOTS = hat_pkg::DefSlots
) (
   input logic     clock,
   input logic     reset,
   hat_req_if.sink req_bus,
   hat_rsp_if.source rsp_bus
);
   import hat_pkg::*;

   hat_cmd_type cmd;
   hat_sts_type sts;

   hat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hat_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_bus.kind),
      .req_handle      (req_bus.handle),
      .req_host_handle (req_bus.host_handle),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_slot_out    (rsp_bus.slot_out),
      .rsp_value_out   (rsp_bus.value_out),
      .rsp_is_release  (rsp_bus.is_release),
      .rsp_last        (rsp_bus.last)
   );

   // at most one result load per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.emit_release, cmd.emit_empty}))
      else $error("two result loads in one cycle");

   // a result is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_release || cmd.emit_empty) |-> sts.out_free)
      else $error("result load into a full output register");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while busy");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import hat_pkg::*;

   localparam int Slots = DefSlots;

   typedef struct packed {
      logic             status;
      logic [SlotW-1:0] slot;
      logic [HostW-1:0] value;
      logic             is_release;
      logic             last;
   } table_rsp_t;

   // Slot allocator shadow: tracks the open bitmap, stored host handles and the
   // user count, and queues the response beats each accepted request produces.
   class handle_table_model;
      bit [Slots-1:0]   used;
      logic [HostW-1:0] host_tab [Slots];
      bit [CountW-1:0]  users;
      table_rsp_t       pending_results [$];
      int               mismatches;

      function new();
         used = '0;
         used[2:0] = 3'b111;
         for (int i = 0; i < Slots; i++) host_tab[i] = '0;
         host_tab[0] = 16'd0;
         host_tab[1] = 16'd1;
         host_tab[2] = 16'd2;
         users = '0;
         mismatches = 0;
      endfunction

      function void push(bit status, int slot, logic [HostW-1:0] value, bit rel, bit last);
         table_rsp_t r;
         r.status     = status;
         r.slot       = slot[SlotW-1:0];
         r.value      = value;
         r.is_release = rel;
         r.last       = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(logic [KindW-1:0] kind, logic signed [HandleW-1:0] handle,
                                 logic [HostW-1:0] host);
         int h;
         int hits;
         bit found;
         bit open_slot;
         h = int'(handle);
         open_slot = (h >= 0) && (h < Slots) && used[h];
         case (kind)
            KindOpen: begin
               found = 1'b0;
               for (int s = 0; s < Slots; s++) begin
                  if (!found && !used[s]) begin
                     found = 1'b1;
                     used[s] = 1'b1;
                     host_tab[s] = host;
                     push(1'b0, s, host, 1'b0, 1'b1);
                  end
               end
               if (!found) push(1'b1, 0, '0, 1'b0, 1'b1);
            end
            KindClose: begin
               if (open_slot) begin
                  used[h] = 1'b0;
                  push(1'b0, h, '0, 1'b0, 1'b1);
               end else begin
                  push(1'b1, 0, '0, 1'b0, 1'b1);
               end
            end
            KindLookup: begin
               if (open_slot) push(1'b0, h, host_tab[h], 1'b0, 1'b1);
               else push(1'b1, 0, '0, 1'b0, 1'b1);
            end
            KindAdd: begin
               if (users == '1) begin
                  push(1'b1, 0, '0, 1'b0, 1'b1);
               end else begin
                  users++;
                  push(1'b0, 0, '0, 1'b0, 1'b1);
               end
            end
            KindDrop: begin
               if (users == '0) begin
                  push(1'b1, 0, '0, 1'b0, 1'b1);
               end else begin
                  users--;
                  if (users != '0) begin
                     push(1'b0, 0, '0, 1'b0, 1'b1);
                  end else begin
                     // last user gone: release every open slot above the reserved ones
                     hits = 0;
                     for (int s = FirstFree; s < Slots; s++) begin
                        if (used[s]) begin
                           if (hits < MaxResults) begin
                              push(1'b0, s, host_tab[s], 1'b1, 1'b0);
                              hits++;
                           end
                           used[s] = 1'b0;
                        end
                     end
                     if (hits == 0) push(1'b0, 0, '0, 1'b0, 1'b1);
                     else pending_results[pending_results.size()-1].last = 1'b1;
                  end
               end
            end
            default: push(1'b1, 0, '0, 1'b0, 1'b1);
         endcase
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(table_rsp_t got);
         table_rsp_t want;
         if (pending_results.size() == 0) begin
            report($sformatf("rsp beat with nothing pending (slot %0d value %h)",
                             got.slot, got.value));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %b want %b", got.status, want.status));
         if (got.slot !== want.slot)
            report($sformatf("slot_out got %0d want %0d", got.slot, want.slot));
         if (got.value !== want.value)
            report($sformatf("value_out got %h want %h", got.value, want.value));
         if (got.is_release !== want.is_release)
            report($sformatf("is_release got %b want %b", got.is_release, want.is_release));
         if (got.last !== want.last)
            report($sformatf("last got %b want %b", got.last, want.last));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   tx_calm;
   bit   rx_calm;
   int   items_sent;

   handle_table_model tbl = new();

   hat_req_if req_bus ();
   hat_rsp_if rsp_bus ();

   handle_allocation_table #(
      .SLOTS(Slots)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(10ms);
      $display("RESULT: ERROR");
      $finish;
   end

   // 0 most of the time; otherwise a pause, mostly short, now and then long
   function automatic int pick_pause(bit calm, int busy_pct);
      int r;
      if (calm || $urandom_range(0, 99) >= busy_pct) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   initial begin
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      forever begin
         repeat ($urandom_range(40, 300)) @(posedge clock);
         tx_calm <= ($urandom_range(0, 3) == 0);
         rx_calm <= ($urandom_range(0, 3) == 0);
      end
   end

   // response side: sample the beat, then decide ready for the next edge
   initial begin
      int stall_left;
      int n;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            tbl.check_result('{rsp_bus.status, rsp_bus.slot_out, rsp_bus.value_out,
                               rsp_bus.is_release, rsp_bus.last});
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            n = pick_pause(rx_calm, 30);
            rsp_bus.ready <= (n == 0);
            if (n > 0) stall_left = n - 1;
         end
      end
   end

   task automatic issue(input logic [KindW-1:0] kind, input logic signed [HandleW-1:0] handle,
                        input logic [HostW-1:0] host);
      int gap;
      gap = pick_pause(tx_calm, 50);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.handle      <= handle;
      req_bus.host_handle <= host;
      do @(posedge clock); while (!req_bus.ready);
      tbl.note_request(kind, handle, host);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tbl.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [HostW-1:0] rand_host();
      return HostW'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic signed [HandleW-1:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return HandleW'($urandom_range(0, Slots - 1));
      if (r < 85) return HandleW'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0: return HandleW'(Slots);
         1: return HandleW'(Slots - 1);
         2: return HandleW'(-1);
         3: return HandleW'(127);
         default: return HandleW'(-128);
      endcase
   endfunction

   task automatic random_op();
      int r;
      logic [KindW-1:0] kind;
      r = $urandom_range(0, 99);
      if (r < 30) kind = KindOpen;
      else if (r < 50) kind = KindClose;
      else if (r < 70) kind = KindLookup;
      else if (r < 80) kind = KindAdd;
      else if (r < 92) kind = KindDrop;
      else kind = KindW'($urandom_range(KindDrop + 1, {KindW{1'b1}}));
      issue(kind, pick_handle(), rand_host());
   endtask

   initial begin
      int start_cnt;
      int choice;
      int len;
      int k;
      int n;
      items_sent = 0;
      reset <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KindOpen;
      req_bus.handle      <= '0;
      req_bus.host_handle <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reserved slots, bad handles, slots never opened
      issue(KindLookup, HandleW'(0), 16'h0);
      issue(KindLookup, HandleW'(1), 16'h0);
      issue(KindLookup, HandleW'(2), 16'h0);
      issue(KindLookup, HandleW'(-128), 16'h0);
      issue(KindLookup, HandleW'(127), 16'hFFFF);
      issue(KindLookup, HandleW'(Slots), 16'h0);
      issue(KindClose, HandleW'(-1), 16'h0);
      issue(KindLookup, HandleW'(5), 16'h0);
      issue(KindClose, HandleW'(3), 16'h0);
      issue(KindOpen, HandleW'(0), 16'hFFFF);
      issue(KindOpen, HandleW'(-1), 16'h0000);
      // a reserved slot can be closed and handed out again
      issue(KindClose, HandleW'(1), 16'h0);
      issue(KindOpen, HandleW'(0), 16'hA5A5);
      issue(KindLookup, HandleW'(1), 16'h0);
      issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindAdd, HandleW'(0), 16'h0);
      issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindAdd, HandleW'(0), 16'h0);
      issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindW'(KindDrop + 1), 8'sh55, 16'h5555);
      issue(KindW'(KindDrop + 2), 8'shAA, 16'hAAAA);
      issue({KindW{1'b1}}, HandleW'(-1), 16'hFFFF);
      issue(KindAdd, HandleW'(0), 16'h0);
      issue(KindAdd, HandleW'(0), 16'h0);
      issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindDrop, HandleW'(0), 16'h0);
      wait_drained();

      start_cnt = items_sent;
      while (items_sent - start_cnt < 190) begin
         choice = $urandom_range(0, 99);
         if (choice < 40) begin
            repeat ($urandom_range(1, 12)) random_op();
         end else if (choice < 60) begin
            // open burst, long enough at times to fill the table
            len = $urandom_range(1, Slots + 3);
            repeat (len) issue(KindOpen, pick_handle(), rand_host());
         end else if (choice < 78) begin
            k = $urandom_range(1, 3);
            repeat (k) issue(KindAdd, pick_handle(), rand_host());
            repeat ($urandom_range(0, 6)) random_op();
            if ($urandom_range(0, 3) == 0) k++;
            repeat (k) issue(KindDrop, pick_handle(), rand_host());
         end else if (choice < 90) begin
            len = $urandom_range(1, 8);
            repeat (len) issue($urandom_range(0, 1) ? KindClose : KindLookup,
                               HandleW'($urandom_range(0, Slots - 1)), rand_host());
         end else if (choice < 96) begin
            issue(KindW'($urandom_range(KindDrop + 1, {KindW{1'b1}})),
                  HandleW'($urandom_range(0, 255)), rand_host());
         end else begin
            wait_drained();
         end
      end

      // drop every user, then a full table swept by the final drop
      wait_drained();
      n = int'(tbl.users);
      repeat (n) issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindAdd, HandleW'(0), 16'h0);
      repeat (Slots) issue(KindOpen, HandleW'(0), rand_host());
      issue(KindDrop, HandleW'(0), 16'h0);
      issue(KindLookup, HandleW'(Slots - 1), 16'h0);

      wait_drained();
      repeat (64) @(posedge clock);
      if (tbl.mismatches == 0 && tbl.pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
